[rtl/glr_pkg.sv]
// ----------------------------------------------------------------------------
// glr_pkg: shared types and constants for the glyph line rasterizer
// Transaction payloads, sequencer control word, microcode program and glyph
// codes.
// ----------------------------------------------------------------------------
package glr_pkg;

   localparam int COORD_BITS = 6;
   localparam int CFG_BITS   = 7;
   localparam int CSR_IDX_BITS = 1;
   localparam int GLYPH_BITS = 7;
   localparam int ERR_BITS   = COORD_BITS + 3;
   localparam int E2_BITS    = ERR_BITS + 1;
   localparam int PROD_BITS  = COORD_BITS + 12;
   localparam int CMP_BITS   = (COORD_BITS > CFG_BITS) ? COORD_BITS + 1 : CFG_BITS + 1;
   localparam int STEP_BITS  = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_COLS = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_ROWS = CSR_IDX_BITS'(1);
   localparam logic [CFG_BITS-1:0] GRID_RESET = CFG_BITS'(64);

   localparam logic [GLYPH_BITS-1:0] GLYPH_NONE       = 7'h00;
   localparam logic [GLYPH_BITS-1:0] GLYPH_SPACE      = 7'h20;
   localparam logic [GLYPH_BITS-1:0] GLYPH_DOT        = 7'h2E;
   localparam logic [GLYPH_BITS-1:0] GLYPH_BAR        = 7'h7C;
   localparam logic [GLYPH_BITS-1:0] GLYPH_UNDERSCORE = 7'h5F;
   localparam logic [GLYPH_BITS-1:0] GLYPH_SLASH      = 7'h2F;
   localparam logic [GLYPH_BITS-1:0] GLYPH_BACKSLASH  = 7'h5C;

   localparam int SLOPE_UNIT = 1000;
   localparam int SLOPE_LOW  = 414;
   localparam int SLOPE_HIGH = 2414;

   typedef logic [STEP_BITS-1:0] step_type;

   localparam step_type STEP_WAIT  = STEP_BITS'(0);
   localparam step_type STEP_GLYPH = STEP_BITS'(1);
   localparam step_type STEP_FIRST = STEP_BITS'(2);
   localparam step_type STEP_WALK  = STEP_BITS'(3);
   localparam step_type STEP_EMPTY = STEP_BITS'(4);

   typedef enum logic [1:0] {
      COND_ALWAYS   = 2'd0,
      COND_SAME     = 2'd1,
      COND_NEXT_END = 2'd2
   } cond_type;

   typedef struct packed {
      logic     wait_req;
      logic     calc_glyph;
      logic     advance;
      logic     emit_cell;
      logic     emit_empty;
      logic     need_out;
      cond_type cond;
      step_type jump_step;
      step_type next_step;
   } ucode_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] start_row;
      logic [COORD_BITS-1:0] start_col;
      logic [COORD_BITS-1:0] end_row;
      logic [COORD_BITS-1:0] end_col;
      logic                  erase;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_row;
      logic [COORD_BITS-1:0] pixel_col;
      logic [GLYPH_BITS-1:0] glyph;
      logic                  write_enable;
      logic                  last;
   } rsp_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      word = '0;
      word.cond = COND_ALWAYS;
      word.jump_step = STEP_WAIT;
      word.next_step = STEP_WAIT;
      unique case (step)
         STEP_WAIT: begin
            word.wait_req  = 1'b1;
            word.jump_step = STEP_GLYPH;
         end
         STEP_GLYPH: begin
            word.calc_glyph = 1'b1;
            word.cond       = COND_SAME;
            word.jump_step  = STEP_EMPTY;
            word.next_step  = STEP_FIRST;
         end
         STEP_FIRST: begin
            word.advance   = 1'b1;
            word.cond      = COND_NEXT_END;
            word.jump_step = STEP_EMPTY;
            word.next_step = STEP_WALK;
         end
         STEP_WALK: begin
            word.advance   = 1'b1;
            word.emit_cell = 1'b1;
            word.need_out  = 1'b1;
            word.cond      = COND_NEXT_END;
            word.jump_step = STEP_WAIT;
            word.next_step = STEP_WALK;
         end
         STEP_EMPTY: begin
            word.emit_empty = 1'b1;
            word.need_out   = 1'b1;
            word.jump_step  = STEP_WAIT;
         end
         default: begin
            word.jump_step = STEP_WAIT;
         end
      endcase
      return word;
   endfunction

endpackage

[rtl/glyph_line_rasterizer.sv]
// Sequencing: an accepted line passes through the glyph step and, unless its
// ends coincide, the first step; the walk step then emits its interior cells,
// one per cycle while the output register can take them, and a line with none
// emits one empty result. The next line is accepted once the last is loaded.
// Reset (synchronous, active high) returns the sequencer to its wait step,
// empties the output register and sets both grid bounds to 64.
// ----------------------------------------------------------------------------
// glyph_line_rasterizer
// Microcoded Bresenham line walker that emits one glyph result per interior
// cell of each line transaction (write enabled only inside the grid bounds).
// ----------------------------------------------------------------------------
module glyph_line_rasterizer
   import glr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata
);

   step_type                     step_ff, step_in;
   logic [CFG_BITS-1:0]          grid_cols_ff, grid_cols_in;
   logic [CFG_BITS-1:0]          grid_rows_ff, grid_rows_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_data_ff, rsp_data_in;

   logic [COORD_BITS-1:0]        row_ff, row_in;
   logic [COORD_BITS-1:0]        col_ff, col_in;
   logic [COORD_BITS-1:0]        target_row_ff, target_row_in;
   logic [COORD_BITS-1:0]        target_col_ff, target_col_in;
   logic [COORD_BITS-1:0]        abs_dr_ff, abs_dr_in;
   logic [COORD_BITS-1:0]        abs_dc_ff, abs_dc_in;
   logic signed [ERR_BITS-1:0]   err_ff, err_in;
   logic                         row_up_ff, row_up_in;
   logic                         col_up_ff, col_up_in;
   logic                         erase_ff, erase_in;
   logic [GLYPH_BITS-1:0]        glyph_ff, glyph_in;

   ucode_type                    uc;
   logic                         out_free;
   logic                         go;
   logic                         out_load;
   logic                         cond_true;

   logic signed [E2_BITS-1:0]    e2;
   logic signed [E2_BITS-1:0]    dr_ext;
   logic signed [E2_BITS-1:0]    dc_ext;
   logic                         row_move;
   logic                         col_move;
   logic [COORD_BITS-1:0]        row_next;
   logic [COORD_BITS-1:0]        col_next;
   logic signed [ERR_BITS-1:0]   err_next;
   logic                         next_end;
   logic                         same_cell;
   logic                         in_bounds;

   logic [PROD_BITS-1:0]         dc_scaled;
   logic [PROD_BITS-1:0]         dr_low;
   logic [PROD_BITS-1:0]         dr_high;
   logic [GLYPH_BITS-1:0]        slope_glyph;

   always_comb begin
      uc       = ucode_rom(step_ff);
      out_free = !rsp_valid_ff || rsp_ready;
      go       = (!uc.wait_req || req_valid) && (!uc.need_out || out_free);
      out_load = go && (uc.emit_cell || uc.emit_empty);
   end

   assign req_ready = uc.wait_req;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Bresenham step
   always_comb begin
      dr_ext   = $signed({{(E2_BITS-COORD_BITS){1'b0}}, abs_dr_ff});
      dc_ext   = $signed({{(E2_BITS-COORD_BITS){1'b0}}, abs_dc_ff});
      e2       = $signed({err_ff, 1'b0});
      row_move = e2 >= -dc_ext;
      col_move = e2 <= dr_ext;
      row_next = row_ff;
      col_next = col_ff;
      err_next = err_ff;
      if (row_move) begin
         row_next = row_up_ff ? row_ff + 1'b1 : row_ff - 1'b1;
      end
      if (col_move) begin
         col_next = col_up_ff ? col_ff + 1'b1 : col_ff - 1'b1;
      end
      err_next = ERR_BITS'(err_ff - (row_move ? ERR_BITS'(dc_ext) : ERR_BITS'(0))
                                  + (col_move ? ERR_BITS'(dr_ext) : ERR_BITS'(0)));
      next_end  = (row_next == target_row_ff) && (col_next == target_col_ff);
      same_cell = (abs_dr_ff == '0) && (abs_dc_ff == '0);
      in_bounds = (CMP_BITS'(row_ff) < CMP_BITS'(grid_rows_ff))
               && (CMP_BITS'(col_ff) < CMP_BITS'(grid_cols_ff));
   end

   // Slope classification
   always_comb begin
      dc_scaled = PROD_BITS'(abs_dc_ff) * PROD_BITS'(SLOPE_UNIT);
      dr_low    = PROD_BITS'(abs_dr_ff) * PROD_BITS'(SLOPE_LOW);
      dr_high   = PROD_BITS'(abs_dr_ff) * PROD_BITS'(SLOPE_HIGH);
      priority if (same_cell) begin
         slope_glyph = GLYPH_DOT;
      end else if ((abs_dr_ff != '0) && (dc_scaled < dr_low)) begin
         slope_glyph = GLYPH_BAR;
      end else if ((abs_dr_ff == '0) || (dc_scaled > dr_high)) begin
         slope_glyph = GLYPH_UNDERSCORE;
      end else if (row_up_ff != col_up_ff) begin
         slope_glyph = GLYPH_SLASH;
      end else begin
         slope_glyph = GLYPH_BACKSLASH;
      end
   end

   always_comb begin
      unique case (uc.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_SAME:     cond_true = same_cell;
         COND_NEXT_END: cond_true = next_end;
         default:       cond_true = 1'b1;
      endcase
   end

   always_comb begin
      step_in       = step_ff;
      grid_cols_in  = grid_cols_ff;
      grid_rows_in  = grid_rows_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      target_row_in = target_row_ff;
      target_col_in = target_col_ff;
      abs_dr_in     = abs_dr_ff;
      abs_dc_in     = abs_dc_ff;
      err_in        = err_ff;
      row_up_in     = row_up_ff;
      col_up_in     = col_up_ff;
      erase_in      = erase_ff;
      glyph_in      = glyph_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_COLS: grid_cols_in = csr_wdata;
            CSR_GRID_ROWS: grid_rows_in = csr_wdata;
            default: ;
         endcase
      end

      if (go) begin
         step_in = cond_true ? uc.jump_step : uc.next_step;
      end

      if (go && uc.wait_req) begin
         row_in        = req_data.start_row;
         col_in        = req_data.start_col;
         target_row_in = req_data.end_row;
         target_col_in = req_data.end_col;
         row_up_in     = req_data.start_row < req_data.end_row;
         col_up_in     = req_data.start_col < req_data.end_col;
         abs_dr_in     = (req_data.end_row > req_data.start_row)
                       ? req_data.end_row - req_data.start_row
                       : req_data.start_row - req_data.end_row;
         abs_dc_in     = (req_data.end_col > req_data.start_col)
                       ? req_data.end_col - req_data.start_col
                       : req_data.start_col - req_data.end_col;
         err_in        = $signed(ERR_BITS'(abs_dr_in)) - $signed(ERR_BITS'(abs_dc_in));
         erase_in      = req_data.erase;
      end

      if (go && uc.calc_glyph) begin
         glyph_in = erase_ff ? GLYPH_SPACE : slope_glyph;
      end

      if (go && uc.advance) begin
         row_in = row_next;
         col_in = col_next;
         err_in = err_next;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
         if (uc.emit_cell) begin
            rsp_data_in.pixel_row    = row_ff;
            rsp_data_in.pixel_col    = col_ff;
            rsp_data_in.glyph        = glyph_ff;
            rsp_data_in.write_enable = in_bounds;
            rsp_data_in.last         = next_end;
         end else begin
            rsp_data_in.pixel_row    = '0;
            rsp_data_in.pixel_col    = '0;
            rsp_data_in.glyph        = GLYPH_NONE;
            rsp_data_in.write_enable = 1'b0;
            rsp_data_in.last         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_WAIT;
         grid_cols_ff <= GRID_RESET;
         grid_rows_ff <= GRID_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         grid_cols_ff <= grid_cols_in;
         grid_rows_ff <= grid_rows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      target_row_ff <= target_row_in;
      target_col_ff <= target_col_in;
      abs_dr_ff     <= abs_dr_in;
      abs_dc_ff     <= abs_dc_in;
      err_ff        <= err_in;
      row_up_ff     <= row_up_in;
      col_up_ff     <= col_up_in;
      erase_ff      <= erase_in;
      glyph_ff      <= glyph_in;
      rsp_data_ff   <= rsp_data_in;
   end

   a_accept_to_glyph: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (step_ff == STEP_GLYPH))
      else $error("accepted transaction did not advance to glyph step");

   a_walk_not_at_end: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_WALK) |-> !((row_ff == target_row_ff) && (col_ff == target_col_ff)))
      else $error("walker reached end cell while still emitting");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (out_load && uc.emit_empty) |=> (rsp_valid_ff && rsp_data_ff.last
                                        && !rsp_data_ff.write_enable))
      else $error("empty line result malformed");

   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_data_in.last) |=> (step_ff == STEP_WAIT))
      else $error("sequencer did not return to wait after last result");

endmodule
